// ===== rtl/core/m4inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared widths, codes and control types of the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package m4inv_pkg;

    localparam int ELEM_W = 32;                       // element width, Q format
    localparam int FRAC_W = 16;                       // fractional bits
    localparam int ACC_W  = 4 * ELEM_W + 4;           // minors and determinant
    localparam int DEN_W  = ACC_W + 1;                // twice the determinant
    localparam int NUM_W  = ACC_W + ELEM_W + 2 * FRAC_W;
    localparam int NUM_SH = 2 * FRAC_W + 1;
    localparam int CNT_W  = $clog2(ELEM_W);

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_RDB, S_LDB, S_MUL, S_MDONE, S_DCHK,
        S_DV0, S_DV1, S_DV2, S_DV3, S_DVS, S_OLD, S_OWAIT
    } t_state;

    typedef enum logic [1:0] {
        PH_M2, PH_M3, PH_DET
    } t_phase;

    typedef enum logic [1:0] {
        BS_ELEM, BS_M2, BS_MIN
    } t_bsrc;

    typedef struct packed {
        logic       wr_en;
        logic [3:0] mat_addr;
        logic [3:0] min_addr;
        logic       lat_a;
        logic       lat_b;
        t_bsrc      bsrc;
        logic [1:0] sel;
        logic       acc_clr;
        logic       mac_step;
        logic       mac_sub;
        logic       mac_last;
        logic       m2_wr;
        logic       min_wr;
        logic       det_wr;
        logic       dv_mag;
        logic       odd;
        logic       dv_num;
        logic       dv_init;
        logic       dv_step;
        logic       out_load;
        logic [3:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
    } t_stat;

    // n-th of the three indexes left after dropping index s
    function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] s);
        skip_idx = (n < s) ? n : n + 2'd1;
    endfunction

endpackage

// ===== rtl/core/matrix4x4_general_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_general_inverse
// 4x4 inverse by cofactors and adjugate in signed Q16.16, saturated results.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  load    | in        | i_in_valid / o_in_ready   | row, col, element, start
//  inverse | out       | o_out_valid / i_out_ready | row, col, value, flags
//
//  A load without start only writes its element. A load with start runs the
//  inversion: 16 minors of nine multiply-accumulates each plus four for the
//  determinant, each multiply on the shared bit-serial MAC, then one division
//  per element on the bit-serial divider (no division if singular).
//  Each finished item holds in the output register until taken; the next
//  element is worked out only after that. Loads are refused until the
//  sixteenth element is taken. Reset clears the element store to zero.
// ----------------------------------------------------------------------------
module matrix4x4_general_inverse
    import m4inv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_row_index,
    input  logic [1:0]        i_col_index,
    input  logic [ELEM_W-1:0] i_elem_value,
    input  logic              i_start_invert,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_out_row,
    output logic [1:0]        o_out_col,
    output logic [ELEM_W-1:0] o_inv_value,
    output logic              o_singular,
    output logic              o_saturated,
    output logic              o_last_out
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: walks minors, determinant, divisions and output handoff
    m4inv_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_start_invert (i_start_invert),
        .i_out_ready    (i_out_ready),
        .i_stat         (stat),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .o_cmd          (cmd)
    );

    // datapath: element store, MAC, minor store, divider, output register
    m4inv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_elem_value (i_elem_value),
        .o_stat       (stat),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_inv_value  (o_inv_value),
        .o_singular   (o_singular),
        .o_saturated  (o_saturated),
        .o_last_out   (o_last_out)
    );

    // loads and results never overlap
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("load accepted while a result is pending");

    // the last item is always the bottom-right element
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_out) |-> (o_out_row == 2'd3 && o_out_col == 2'd3))
        else $error("last marker on wrong element");

    // a singular matrix yields plain zeros
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_singular) |-> (o_inv_value == '0 && !o_saturated))
        else $error("singular result not zero");

    // after the last item is taken, loads open again
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_out) |=> o_in_ready)
        else $error("block not idle after final result");

endmodule

// ===== rtl/core/m4inv_dp.sv =====
// ----------------------------------------------------------------------------
// m4inv_dp
// Element store, serial multiply-accumulate, minor store and serial divider.
// ----------------------------------------------------------------------------
module m4inv_dp
    import m4inv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [1:0]        i_row_index,
    input  logic [1:0]        i_col_index,
    input  logic [ELEM_W-1:0] i_elem_value,
    output t_stat             o_stat,
    output logic [1:0]        o_out_row,
    output logic [1:0]        o_out_col,
    output logic [ELEM_W-1:0] o_inv_value,
    output logic              o_singular,
    output logic              o_saturated,
    output logic              o_last_out
);

    logic [ELEM_W-1:0] r_mat [0:15];
    logic [15:0]       r_vld;
    logic [ELEM_W-1:0] r_erd;
    logic [ACC_W-1:0]  r_min [0:15];
    logic [ACC_W-1:0]  r_mrd;
    logic [ACC_W-1:0]  r_m2 [0:3];
    logic [ELEM_W-1:0] r_ma;
    logic [ACC_W-1:0]  r_mb;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_dmag;
    logic              r_dneg;
    logic              r_zero;
    logic [ACC_W-1:0]  r_cmag;
    logic              r_neg;
    logic [NUM_W-1:0]  r_num;
    logic              r_big;
    logic [DEN_W-1:0]  r_rem;
    logic [ELEM_W-1:0] r_nlo;
    logic [ELEM_W-1:0] r_q;

    logic [DEN_W-1:0]  den;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [ELEM_W-1:0] limit;
    logic              sat;
    logic [ELEM_W-1:0] qv;

    assign den   = {r_dmag, 1'b0};
    assign trial = {r_rem, r_nlo[ELEM_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign limit = (ELEM_W'(1) << (ELEM_W - 1)) - ELEM_W'(!r_neg);
    assign sat   = !r_zero && (r_big || (r_q > limit));
    assign qv    = sat ? limit : r_q;
    assign o_stat.det_zero = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[{i_row_index, i_col_index}] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mat[{i_row_index, i_col_index}] <= i_elem_value;
        end
        r_erd <= r_vld[i_cmd.mat_addr] ? r_mat[i_cmd.mat_addr] : '0;
        if (i_cmd.min_wr) begin
            r_min[i_cmd.min_addr] <= r_acc;
        end
        r_mrd <= r_min[i_cmd.min_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a) begin
            r_ma <= r_erd;
        end
        if (i_cmd.lat_b) begin
            unique case (i_cmd.bsrc)
                BS_ELEM: r_mb <= {{(ACC_W-ELEM_W){r_erd[ELEM_W-1]}}, r_erd};
                BS_M2:   r_mb <= r_m2[i_cmd.sel];
                default: r_mb <= r_mrd;
            endcase
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.mac_step) begin
            // two's complement: the top bit of the element weighs negative
            if (r_ma[0]) begin
                r_acc <= (i_cmd.mac_sub ^ i_cmd.mac_last) ? r_acc - r_mb : r_acc + r_mb;
            end
            r_ma <= r_ma >> 1;
            r_mb <= r_mb << 1;
        end
        if (i_cmd.m2_wr) begin
            r_m2[i_cmd.sel] <= r_acc;
        end
        if (i_cmd.det_wr) begin
            r_dneg <= r_acc[ACC_W-1];
            r_dmag <= r_acc[ACC_W-1] ? -r_acc : r_acc;
            r_zero <= (r_acc == '0);
        end
        if (i_cmd.dv_mag) begin
            r_cmag <= r_mrd[ACC_W-1] ? -r_mrd : r_mrd;
            r_neg  <= r_mrd[ACC_W-1] ^ i_cmd.odd ^ r_dneg;
        end
        if (i_cmd.dv_num) begin
            r_num <= (NUM_W'(r_cmag) << NUM_SH) + NUM_W'(r_dmag);
        end
        if (i_cmd.dv_init) begin
            r_big <= r_num[NUM_W-1:ELEM_W] >= (NUM_W-ELEM_W)'(den);
            r_rem <= r_num[ELEM_W +: DEN_W];
            r_nlo <= r_num[ELEM_W-1:0];
            r_q   <= '0;
        end else if (i_cmd.dv_step) begin
            r_rem <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
            r_q   <= {r_q[ELEM_W-2:0], ge};
            r_nlo <= r_nlo << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_row   <= i_cmd.out_idx[3:2];
            o_out_col   <= i_cmd.out_idx[1:0];
            o_last_out  <= (i_cmd.out_idx == 4'hF);
            o_singular  <= r_zero;
            o_saturated <= sat;
            o_inv_value <= r_zero ? '0 : (r_neg ? -qv : qv);
        end
    end

endmodule

// ===== rtl/core/m4inv_ctrl.sv =====
// ----------------------------------------------------------------------------
// m4inv_ctrl
// Sequencer: minors, determinant, per-element division and result handoff.
// ----------------------------------------------------------------------------
module m4inv_ctrl
    import m4inv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_start_invert,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    t_phase           r_phase;
    logic [3:0]       r_mi;
    logic [1:0]       r_k;
    logic             r_p;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_e;

    logic [1:0] sr, sc, r0, r1, r2, cx, cy, ck;
    logic       cnt_last;

    assign sr = r_mi[3:2];
    assign sc = r_mi[1:0];
    assign r0 = skip_idx(2'd0, sr);
    assign r1 = skip_idx(2'd1, sr);
    assign r2 = skip_idx(2'd2, sr);
    assign cx = skip_idx((r_k == 2'd0) ? 2'd1 : 2'd0, sc);
    assign cy = skip_idx((r_k == 2'd2) ? 2'd1 : 2'd2, sc);
    assign ck = skip_idx(r_k, sc);
    assign cnt_last = (r_cnt == CNT_W'(ELEM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_M2;
            r_mi    <= '0;
            r_k     <= '0;
            r_p     <= 1'b0;
            r_cnt   <= '0;
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_phase <= PH_M2;
                    r_mi    <= '0;
                    r_k     <= '0;
                    r_p     <= 1'b0;
                    r_e     <= '0;
                end
                S_LDB, S_DV3: r_cnt <= '0;
                S_MUL, S_DVS: r_cnt <= r_cnt + 1'b1;
                S_MDONE: begin
                    unique case (r_phase)
                        PH_M2: begin
                            r_p <= !r_p;
                            if (r_p) begin
                                if (r_k == 2'd2) begin
                                    r_phase <= PH_M3;
                                    r_k     <= '0;
                                end else begin
                                    r_k <= r_k + 2'd1;
                                end
                            end
                        end
                        PH_M3: begin
                            if (r_k == 2'd2) begin
                                r_k     <= '0;
                                r_phase <= (r_mi == 4'hF) ? PH_DET : PH_M2;
                                r_mi    <= r_mi + 4'd1;
                            end else begin
                                r_k <= r_k + 2'd1;
                            end
                        end
                        default: r_k <= r_k + 2'd1;
                    endcase
                end
                S_OWAIT: if (i_out_ready) r_e <= r_e + 4'd1;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid && i_start_invert) n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_LDB;
            S_LDB:   n_state = S_MUL;
            S_MUL:   if (cnt_last) n_state = S_MDONE;
            S_MDONE: n_state = (r_phase == PH_DET && r_k == 2'd3) ? S_DCHK : S_RDA;
            S_DCHK:  n_state = i_stat.det_zero ? S_OLD : S_DV0;
            S_DV0:   n_state = S_DV1;
            S_DV1:   n_state = S_DV2;
            S_DV2:   n_state = S_DV3;
            S_DV3:   n_state = S_DVS;
            S_DVS:   if (cnt_last) n_state = S_OLD;
            S_OLD:   n_state = S_OWAIT;
            S_OWAIT: begin
                if (i_out_ready) begin
                    if (r_e == 4'hF) n_state = S_IDLE;
                    else n_state = i_stat.det_zero ? S_OLD : S_DV0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.bsrc     = BS_ELEM;
        o_cmd.sel      = r_k;
        o_cmd.out_idx  = r_e;
        o_cmd.odd      = r_e[2] ^ r_e[0];
        o_cmd.mac_last = cnt_last;
        unique case (r_phase)
            PH_M2:   o_cmd.mac_sub = r_p;
            PH_M3:   o_cmd.mac_sub = (r_k == 2'd1);
            default: o_cmd.mac_sub = r_k[0];
        endcase
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OWAIT);
        unique case (r_state)
            S_IDLE: o_cmd.wr_en = i_in_valid;
            S_RDA: begin
                unique case (r_phase)
                    PH_M2:   o_cmd.mat_addr = {r1, r_p ? cy : cx};
                    PH_M3:   o_cmd.mat_addr = {r0, ck};
                    default: o_cmd.mat_addr = {2'd0, r_k};
                endcase
            end
            S_RDB: begin
                o_cmd.lat_a    = 1'b1;
                o_cmd.mat_addr = {r2, r_p ? cx : cy};
                o_cmd.min_addr = {2'd0, r_k};
            end
            S_LDB: begin
                o_cmd.lat_b = 1'b1;
                unique case (r_phase)
                    PH_M2:   o_cmd.bsrc = BS_ELEM;
                    PH_M3:   o_cmd.bsrc = BS_M2;
                    default: o_cmd.bsrc = BS_MIN;
                endcase
                o_cmd.acc_clr = (r_phase == PH_M2) ? !r_p : (r_k == 2'd0);
            end
            S_MUL: o_cmd.mac_step = 1'b1;
            S_MDONE: begin
                o_cmd.min_addr = r_mi;
                o_cmd.m2_wr    = (r_phase == PH_M2) && r_p;
                o_cmd.min_wr   = (r_phase == PH_M3) && (r_k == 2'd2);
                o_cmd.det_wr   = (r_phase == PH_DET) && (r_k == 2'd3);
            end
            S_DV0:   o_cmd.min_addr = {r_e[1:0], r_e[3:2]};
            S_DV1:   o_cmd.dv_mag   = 1'b1;
            S_DV2:   o_cmd.dv_num   = 1'b1;
            S_DV3:   o_cmd.dv_init  = 1'b1;
            S_DVS:   o_cmd.dv_step  = 1'b1;
            S_OLD:   o_cmd.out_load = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== dv/matrix4x4_general_inverse_tb.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_general_inverse_tb
// Self-checking bench for the 4x4 fixed-point matrix inverse: loads matrices
// element by element, predicts all sixteen inverse elements with exact wide
// arithmetic, and compares every output item field by field under random
// stalls on both channels.
// ----------------------------------------------------------------------------
module matrix4x4_general_inverse_tb;
    import m4inv_pkg::*;

    localparam int N_RANDOM = 500;
    localparam logic [ELEM_W-1:0] ONE_Q = 1 << FRAC_W;

    // How a directed row's results are known: worked out by the predictor,
    // or typed in because they can be read off at a glance.
    typedef enum logic [2:0] {
        K_PRED, K_SING, K_IDENT, K_SATP, K_SATN
    } t_kind;

    typedef struct {
        logic [1:0]        row;
        logic [1:0]        col;
        logic [ELEM_W-1:0] val;
        logic              start;
        t_kind             kind;
    } t_load;

    typedef struct {
        logic [1:0]        row;
        logic [1:0]        col;
        logic [ELEM_W-1:0] val;
        logic              sing;
        logic              sat;
        logic              last;
    } t_inv_elem;

    typedef logic signed [199:0] t_wide;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_row_index;
    logic [1:0]        i_col_index;
    logic [ELEM_W-1:0] i_elem_value;
    logic              i_start_invert;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [1:0]        o_out_row;
    logic [1:0]        o_out_col;
    logic [ELEM_W-1:0] o_inv_value;
    logic              o_singular;
    logic              o_saturated;
    logic              o_last_out;

    matrix4x4_general_inverse u_top (.*);

    // Bench copy of the element store, written on every accepted load item.
    logic [ELEM_W-1:0] mat_shadow [16];
    t_inv_elem         inv_expected [$];

    int  n_errors   = 0;
    int  n_loads    = 0;
    int  n_inverts  = 0;
    int  n_results  = 0;
    int  n_sing     = 0;
    int  n_sat      = 0;
    bit  idle_on    = 1'b1;   // cleared for the quiet tail of the run
    int  out_stall  = 0;

    // ------------------------------------------------------------------------
    // Clock, and a hard stop well beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #250_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: exact cofactor expansion on wide signed integers
    // ------------------------------------------------------------------------
    function automatic t_wide elem_at(int r, int c);
        logic [ELEM_W-1:0] v;
        v = mat_shadow[r * 4 + c];
        return {{(200 - ELEM_W){v[ELEM_W-1]}}, v};
    endfunction

    // 3x3 determinant of the stored matrix with row sr and column sc removed
    function automatic t_wide minor3(int sr, int sc);
        int    rr [3];
        int    cc [3];
        int    n;
        t_wide m0, m1, m2;
        n = 0;
        for (int k = 0; k < 4; k++) if (k != sr) begin rr[n] = k; n++; end
        n = 0;
        for (int k = 0; k < 4; k++) if (k != sc) begin cc[n] = k; n++; end
        m0 = elem_at(rr[1], cc[1]) * elem_at(rr[2], cc[2])
           - elem_at(rr[1], cc[2]) * elem_at(rr[2], cc[1]);
        m1 = elem_at(rr[1], cc[0]) * elem_at(rr[2], cc[2])
           - elem_at(rr[1], cc[2]) * elem_at(rr[2], cc[0]);
        m2 = elem_at(rr[1], cc[0]) * elem_at(rr[2], cc[1])
           - elem_at(rr[1], cc[1]) * elem_at(rr[2], cc[0]);
        return elem_at(rr[0], cc[0]) * m0 - elem_at(rr[0], cc[1]) * m1
             + elem_at(rr[0], cc[2]) * m2;
    endfunction

    // Queue the sixteen inverse elements of the stored matrix
    task automatic predict_inverse();
        t_wide         det, cof;
        logic [199:0]  dmag, cmag, quot, lim;
        logic          dneg, neg;
        t_inv_elem     e;
        det = '0;
        for (int j = 0; j < 4; j++) begin
            if (j & 1) det = det - elem_at(0, j) * minor3(0, j);
            else       det = det + elem_at(0, j) * minor3(0, j);
        end
        dneg = det[199];
        dmag = dneg ? -det : det;
        for (int k = 0; k < 16; k++) begin
            e.row  = k[3:2];
            e.col  = k[1:0];
            e.sing = (det == 0);
            e.last = (k == 15);
            e.val  = '0;
            e.sat  = 1'b0;
            if (det != 0) begin
                // transposed position gives the adjugate entry
                cof = minor3(k & 3, k >> 2);
                if (((k >> 2) + (k & 3)) & 1) cof = -cof;
                neg  = cof[199] ^ dneg;
                cmag = cof[199] ? -cof : cof;
                // round half away from zero on the magnitude
                quot = ((cmag << (2 * FRAC_W + 1)) + dmag) / (dmag << 1);
                lim  = (200'd1 << (ELEM_W - 1)) - (neg ? 200'd0 : 200'd1);
                if (quot > lim) begin
                    quot  = lim;
                    e.sat = 1'b1;
                end
                e.val = neg ? -quot[ELEM_W-1:0] : quot[ELEM_W-1:0];
            end
            inv_expected.push_back(e);
        end
    endtask

    // Typed-in results for directed rows whose answer is obvious
    task automatic push_known(t_kind kind);
        t_inv_elem e;
        for (int k = 0; k < 16; k++) begin
            e.row  = k[3:2];
            e.col  = k[1:0];
            e.last = (k == 15);
            e.sing = (kind == K_SING);
            e.sat  = 1'b0;
            e.val  = '0;
            if (e.row == e.col) begin
                case (kind)
                    K_IDENT: begin e.val = ONE_Q; end
                    K_SATP:  begin e.val = 32'h7fff_ffff; e.sat = 1'b1; end
                    K_SATN:  begin e.val = 32'h8000_0000; e.sat = 1'b1; end
                    default: begin end
                endcase
            end
            inv_expected.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------------
    // Load side: present one item, hold it until taken, then record it
    // ------------------------------------------------------------------------
    task automatic send_load(t_load ld);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_row_index    <= ld.row;
        i_col_index    <= ld.col;
        i_elem_value   <= ld.val;
        i_start_invert <= ld.start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_loads++;
        mat_shadow[{ld.row, ld.col}] = ld.val;
        if (ld.start) begin
            n_inverts++;
            if (ld.kind == K_PRED) predict_inverse();
            else                   push_known(ld.kind);
        end
    endtask

    // ------------------------------------------------------------------------
    // Inverse side: check each taken item, then pick the next ready level
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_inv_elem e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (inv_expected.size() == 0) begin
                $error("inverse item with nothing expected: row %0d col %0d",
                       o_out_row, o_out_col);
                n_errors++;
            end else begin
                e = inv_expected.pop_front();
                if (o_singular) n_sing++;
                if (o_saturated) n_sat++;
                if (o_out_row !== e.row) begin
                    $error("out_row exp %0d got %0d", e.row, o_out_row);
                    n_errors++;
                end
                if (o_out_col !== e.col) begin
                    $error("out_col exp %0d got %0d", e.col, o_out_col);
                    n_errors++;
                end
                if (o_inv_value !== e.val) begin
                    $error("inv_value exp %h got %h", e.val, o_inv_value);
                    n_errors++;
                end
                if (o_singular !== e.sing) begin
                    $error("singular exp %0b got %0b", e.sing, o_singular);
                    n_errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %0b got %0b", e.sat, o_saturated);
                    n_errors++;
                end
                if (o_last_out !== e.last) begin
                    $error("last_out exp %0b got %0b", e.last, o_last_out);
                    n_errors++;
                end
            end
        end
        // stall in bursts of random length, none in the quiet tail
        if (out_stall > 0) begin
            out_stall--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(1, 11);
        end
        i_out_ready <= (out_stall == 0);
    end

    // Random element value in one of several magnitude classes
    function automatic logic [ELEM_W-1:0] rand_elem(int cls);
        case (cls)
            0:       return $urandom();                                 // full range
            1:       return ($urandom_range(0, 17) - 8) * ONE_Q;        // small integers
            2:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) * ONE_Q
                                                        : '0;           // sparse
            default: return $urandom_range(0, 1048576) - 524288;        // +-8.0
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_load directed [] = '{
        // empty store after reset: singular
        '{2'd0, 2'd0, 32'h0000_0000, 1'b1, K_SING},
        // identity
        '{2'd0, 2'd0, ONE_Q,         1'b0, K_PRED},
        '{2'd1, 2'd1, ONE_Q,         1'b0, K_PRED},
        '{2'd2, 2'd2, ONE_Q,         1'b0, K_PRED},
        '{2'd3, 2'd3, ONE_Q,         1'b1, K_IDENT},
        // smallest positive diagonal: inverse clips high
        '{2'd0, 2'd0, 32'h0000_0001, 1'b0, K_PRED},
        '{2'd1, 2'd1, 32'h0000_0001, 1'b0, K_PRED},
        '{2'd2, 2'd2, 32'h0000_0001, 1'b0, K_PRED},
        '{2'd3, 2'd3, 32'h0000_0001, 1'b1, K_SATP},
        // smallest negative diagonal: inverse clips low
        '{2'd0, 2'd0, 32'hffff_ffff, 1'b0, K_PRED},
        '{2'd1, 2'd1, 32'hffff_ffff, 1'b0, K_PRED},
        '{2'd2, 2'd2, 32'hffff_ffff, 1'b0, K_PRED},
        '{2'd3, 2'd3, 32'hffff_ffff, 1'b1, K_SATN},
        // zero row: singular again
        '{2'd1, 2'd1, 32'h0000_0000, 1'b1, K_SING},
        // extreme element values
        '{2'd1, 2'd1, 32'h7fff_ffff, 1'b0, K_PRED},
        '{2'd0, 2'd3, 32'h8000_0000, 1'b0, K_PRED},
        '{2'd3, 2'd0, 32'h7fff_ffff, 1'b0, K_PRED},
        '{2'd2, 2'd1, 32'h8000_0000, 1'b1, K_PRED},
        // diagonal matrix again: thirds, a tiny inverse rounded near zero, one clipped low
        '{2'd0, 2'd3, 32'h0000_0000, 1'b0, K_PRED},
        '{2'd3, 2'd0, 32'h0000_0000, 1'b0, K_PRED},
        '{2'd2, 2'd1, 32'h0000_0000, 1'b0, K_PRED},
        '{2'd0, 2'd0, 32'h0003_0000, 1'b0, K_PRED},
        '{2'd2, 2'd2, 32'hfffd_0000, 1'b1, K_PRED}
    };

    initial begin
        t_load ld;
        int    order [16];
        int    sent;
        int    cls;
        int    tmp;
        int    pick;
        int    wait_cycles;

        for (int k = 0; k < 16; k++) mat_shadow[k] = '0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_row_index    <= '0;
        i_col_index    <= '0;
        i_elem_value   <= '0;
        i_start_invert <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) send_load(directed[n]);

        // Mostly whole matrices loaded in shuffled order with start on the
        // final load; the rest are stray loads and early starts.
        sent = 0;
        while (sent < N_RANDOM) begin
            if (sent > N_RANDOM * 4 / 5) idle_on = 1'b0;
            ld.kind = K_PRED;
            if ($urandom_range(0, 9) < 8) begin
                cls = $urandom_range(0, 9);
                cls = (cls == 0) ? 0 : (cls < 3) ? 1 : (cls == 3) ? 2 : 3;
                for (int k = 0; k < 16; k++) order[k] = k;
                for (int k = 15; k > 0; k--) begin
                    pick = $urandom_range(0, k);
                    tmp = order[k]; order[k] = order[pick]; order[pick] = tmp;
                end
                for (int k = 0; k < 16; k++) begin
                    ld.row   = 2'(order[k] >> 2);
                    ld.col   = 2'(order[k] & 3);
                    ld.val   = rand_elem(cls);
                    ld.start = (k == 15);
                    send_load(ld);
                    sent++;
                end
            end else begin
                ld.row   = 2'($urandom_range(0, 3));
                ld.col   = 2'($urandom_range(0, 3));
                ld.val   = rand_elem($urandom_range(0, 3));
                ld.start = ($urandom_range(0, 3) == 0);
                send_load(ld);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        // drain, then watch for stray items
        while (inv_expected.size() != 0) @(posedge i_clk);
        wait_cycles = 200;
        repeat (wait_cycles) @(posedge i_clk);

        $display("covered %0d loads, %0d inversions, %0d inverse items checked",
                 n_loads, n_inverts, n_results);
        $display("of those, %0d singular and %0d clipped items", n_sing, n_sat);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/m4inv_pkg.sv
rtl/core/m4inv_dp.sv
rtl/core/m4inv_ctrl.sv
rtl/core/matrix4x4_general_inverse.sv
dv/matrix4x4_general_inverse_tb.sv
